// File: sv/sdas_pkg.sv
// SCAN disk arm scheduler: shared constants, state enum and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package sdas_pkg;

  localparam int MaxBatch = 32;
  localparam int CylW     = 10;
  localparam int TotW     = CylW + 1;
  localparam int CntW     = $clog2(MaxBatch + 1);
  localparam int IdxW     = (MaxBatch > 1) ? $clog2(MaxBatch) : 1;
  localparam int InDataW  = ((CylW + 7) / 8) * 8;
  localparam int OutDataW = ((CylW + TotW + 7) / 8) * 8;
  localparam int OutUserW = 2;
  localparam int RegIdxW  = 1;

  localparam logic [RegIdxW-1:0] RegStart = 1'b0;
  localparam logic [RegIdxW-1:0] RegTop   = 1'b1;

  localparam logic [CylW-1:0] StartReset = '0;
  localparam logic [CylW-1:0] TopReset   = CylW'(999);

  typedef enum logic [1:0] {
    StIdle,
    StUp,
    StTurn,
    StDown
  } sdas_state_e;

  typedef struct packed {
    logic            load;      // insert accepted request into sorted store
    logic            init;      // start of scheduling: arm to start, travel to zero
    logic            emit;      // load output register with a stop
    logic            emit_top;  // stop is the turnaround at top
    logic            last;      // final stop of the batch
    logic            clear;     // end of batch
    logic [IdxW-1:0] addr;      // store entry read for the stop
  } sdas_cmd_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            ge_start;  // saturated entry at addr is at or above start
    logic            out_free;
  } sdas_status_t;

endpackage

// File: sv/scan_disk_arm_scheduler_unit.sv
// SCAN disk arm scheduler top level: configuration registers, controller and datapath.
// Depends on sdas_pkg, sdas_ctrl and sdas_dpath.
// A request not marked last is taken while idle and gives no result. After the last
// request of a batch, the scheduler walks the sorted store upward, emitting each stored
// request at or above start, ends the upward sweep, emits the turnaround at top, then
// walks down through the requests below start; output stalls hold the walk.
// No request is taken while a batch is scheduled. Reset clears count and flag and
// sets the start and top registers to their reset values.
`timescale 1ns / 1ps
module scan_disk_arm_scheduler_unit import sdas_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RegIdxW-1:0]  cfg_idx_i,
  input  logic [CylW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // request_cylinder, zero pad
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // stop_cylinder, movement_total, zero pad
  output logic [OutUserW-1:0] m_axis_tuser,   // turn_point, dropped_requests
  output logic                m_axis_tlast
);

  logic [CylW-1:0] start_q, start_d;
  logic [CylW-1:0] top_q, top_d;

  sdas_cmd_t    cmd;
  sdas_status_t status;

  logic [CylW-1:0] stop;
  logic [TotW-1:0] total;
  logic            turn, drop;

  always_comb begin
    start_d = start_q;
    top_d   = top_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegStart: start_d = cfg_wdata_i;
        RegTop:   top_d   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= StartReset;
      top_q   <= TopReset;
    end else begin
      start_q <= start_d;
      top_q   <= top_d;
    end
  end

  sdas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sdas_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .req_i      (s_axis_tdata[CylW-1:0]),
    .start_i    (start_q),
    .top_i      (top_q),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .stop_o     (stop),
    .total_o    (total),
    .turn_o     (turn),
    .drop_o     (drop),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = OutDataW'({total, stop});
  assign m_axis_tuser = {drop, turn};

endmodule

// File: sv/sdas_ctrl.sv
// SCAN disk arm scheduler: controller state machine.
// Walks the sorted store up, emits the turnaround, then walks down. Uses sdas_pkg.
`timescale 1ns / 1ps
module sdas_ctrl import sdas_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tlast_i,
  output logic         s_tready_o,
  input  sdas_status_t status_i,
  output sdas_cmd_t    cmd_o
);

  sdas_state_e     state_q, state_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] split_q, split_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ptr_q   <= '0;
      split_q <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      split_q <= split_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    split_d    = split_q;
    s_tready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.addr = ptr_q[IdxW-1:0];
    case (state_q)
      StIdle: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          if (s_tlast_i) begin
            cmd_o.init = 1'b1;
            ptr_d      = '0;
            split_d    = '0;
            state_d    = StUp;
          end
        end
      end
      StUp: begin
        if (ptr_q == status_i.count) begin
          state_d = StTurn;
        end else if (!status_i.ge_start) begin
          split_d = ptr_q + CntW'(1);
          ptr_d   = ptr_q + CntW'(1);
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          ptr_d      = ptr_q + CntW'(1);
        end
      end
      StTurn: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_top = 1'b1;
          cmd_o.last     = (split_q == '0);
          if (split_q == '0) begin
            cmd_o.clear = 1'b1;
            state_d     = StIdle;
          end else begin
            ptr_d   = split_q - CntW'(1);
            state_d = StDown;
          end
        end
      end
      StDown: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = (ptr_q == '0);
          if (ptr_q == '0) begin
            cmd_o.clear = 1'b1;
            state_d     = StIdle;
          end else begin
            ptr_d = ptr_q - CntW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  a_up_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StUp |-> ptr_q <= status_i.count)
    else $error("scan pointer past batch");

  a_split_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> split_q <= status_i.count)
    else $error("split beyond batch");

  a_down_ptr_below_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDown |-> ptr_q < split_q)
    else $error("down pointer not below split");

endmodule

// File: sv/sdas_dpath.sv
// SCAN disk arm scheduler: datapath. Sorted insertion store, batch count,
// overflow flag, arm position, travel accumulator and output register. Uses sdas_pkg.
`timescale 1ns / 1ps
module sdas_dpath import sdas_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sdas_cmd_t           cmd_i,
  output sdas_status_t        status_o,
  input  logic [CylW-1:0]     req_i,
  input  logic [CylW-1:0]     start_i,
  input  logic [CylW-1:0]     top_i,
  input  logic                m_tready_i,
  output logic                m_tvalid_o,
  output logic [CylW-1:0]     stop_o,
  output logic [TotW-1:0]     total_o,
  output logic                turn_o,
  output logic                drop_o,
  output logic                last_o
);

  logic [CylW-1:0] store_q [MaxBatch];
  logic [CylW-1:0] store_d [MaxBatch];
  logic [MaxBatch-1:0] gt;

  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [CylW-1:0] cur_q, cur_d;
  logic [TotW-1:0] total_q, total_d;

  logic            ovalid_q, ovalid_d;
  logic [CylW-1:0] ostop_q;
  logic [TotW-1:0] ototal_q;
  logic            oturn_q, olast_q;

  logic [CylW-1:0] rd, sat, pos, hop_len;
  logic [TotW-1:0] tot_nx;
  logic            out_free;

  // Sorted insertion: entries above the new request shift up by one.
  always_comb begin
    for (int i = 0; i < MaxBatch; i++) begin
      gt[i] = (CntW'(i) < count_q) && (store_q[i] > req_i);
    end
    for (int i = 0; i < MaxBatch; i++) begin
      store_d[i] = store_q[i];
      if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
        store_d[i] = store_q[(i > 0) ? i - 1 : 0];
      end else if (gt[i] || CntW'(i) == count_q) begin
        store_d[i] = req_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && count_q < CntW'(MaxBatch)) begin
      store_q <= store_d;
    end
  end

  assign rd       = store_q[cmd_i.addr];
  assign sat      = (rd > top_i) ? top_i : rd;
  assign pos      = cmd_i.emit_top ? top_i : sat;
  assign hop_len  = (pos >= cur_q) ? pos - cur_q : cur_q - pos;
  assign tot_nx   = total_q + TotW'(hop_len);
  assign out_free = !ovalid_q || m_tready_i;

  always_comb begin
    count_d  = count_q;
    ovf_d    = ovf_q;
    cur_d    = cur_q;
    total_d  = total_q;
    ovalid_d = ovalid_q && !m_tready_i;
    if (cmd_i.load) begin
      if (count_q < CntW'(MaxBatch)) begin
        count_d = count_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.init) begin
      cur_d   = start_i;
      total_d = '0;
    end
    if (cmd_i.emit) begin
      cur_d    = pos;
      total_d  = tot_nx;
      ovalid_d = 1'b1;
    end
    if (cmd_i.clear) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ovf_q    <= 1'b0;
      cur_q    <= '0;
      total_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      cur_q    <= cur_d;
      total_q  <= total_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ostop_q  <= pos;
      ototal_q <= tot_nx;
      oturn_q  <= cmd_i.emit_top;
      olast_q  <= cmd_i.last;
    end
  end

  // dropped flag stays with the batch until its final stop is loaded
  logic odrop_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      odrop_q <= ovf_q;
    end
  end

  assign status_o.count    = count_q;
  assign status_o.ge_start = (sat >= start_i);
  assign status_o.out_free = out_free;

  assign m_tvalid_o = ovalid_q;
  assign stop_o     = ostop_q;
  assign total_o    = ototal_q;
  assign turn_o     = oturn_q;
  assign drop_o     = odrop_q;
  assign last_o     = olast_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxBatch))
    else $error("batch count beyond capacity");

  a_ovf_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> count_q == CntW'(MaxBatch))
    else $error("overflow flagged with room left");

  a_turn_at_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && oturn_q |-> ostop_q == top_i)
    else $error("turnaround stop not at top cylinder");

endmodule

// File: tb/sv/sdas_stop_checker.sv
// Stop checker for the SCAN disk arm scheduler: follows register writes and
// accepted request items, predicts every arm stop and compares each output item.
// Depends on sdas_pkg.
`timescale 1ns / 1ps
module sdas_stop_checker import sdas_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RegIdxW-1:0]  cfg_idx_i,
  input  logic [CylW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // request_cylinder, zero pad
  input  logic                s_axis_tlast,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,   // stop_cylinder, movement_total, zero pad
  input  logic [OutUserW-1:0] m_axis_tuser,   // turn_point, dropped_requests
  input  logic                m_axis_tlast,
  output int                  fail_count_o,
  output int                  stops_due_o
);

  typedef struct packed {
    logic [CylW-1:0] cyl;
    logic [TotW-1:0] travel;
    logic            turn;
    logic            lost;
    logic            last;
  } arm_stop_t;

  arm_stop_t       stops_due[$];
  arm_stop_t       want;
  logic [CylW-1:0] batch_cyl [MaxBatch];
  int              batch_len;
  logic            batch_lost;
  logic [CylW-1:0] start_cyl;
  logic [CylW-1:0] top_cyl;

  task automatic report(input string what, input int got, input int exp_val);
    $display("%0t ns: %s got %0d, expected %0d", $time, what, got, exp_val);
    fail_count_o++;
  endtask

  function automatic logic [TotW-1:0] hop(input logic [CylW-1:0] a, input logic [CylW-1:0] b);
    return (a > b) ? TotW'(a - b) : TotW'(b - a);
  endfunction

  function automatic arm_stop_t mk_stop(input logic [CylW-1:0] cyl, input logic [TotW-1:0] travel,
                                        input logic turn, input logic last);
    arm_stop_t s;
    s.cyl    = cyl;
    s.travel = travel;
    s.turn   = turn;
    s.lost   = batch_lost;
    s.last   = last;
    return s;
  endfunction

  // sort the saturated batch, sweep up from the start, turn at top, sweep down
  task automatic plan_scan();
    logic [CylW-1:0] order [MaxBatch];
    logic [CylW-1:0] v;
    logic [CylW-1:0] arm;
    logic [TotW-1:0] travel;
    int              i;
    int              j;
    int              split;
    for (i = 0; i < batch_len; i++) begin
      v = (batch_cyl[i] > top_cyl) ? top_cyl : batch_cyl[i];
      j = i;
      while (j > 0 && order[j-1] > v) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = v;
    end
    arm    = start_cyl;
    travel = '0;
    split  = 0;
    while (split < batch_len && order[split] < arm) split++;
    for (i = split; i < batch_len; i++) begin
      travel += hop(arm, order[i]);
      arm     = order[i];
      stops_due.push_back(mk_stop(arm, travel, 1'b0, 1'b0));
    end
    travel += hop(arm, top_cyl);
    arm     = top_cyl;
    stops_due.push_back(mk_stop(arm, travel, 1'b1, split == 0));
    for (i = split; i > 0; i--) begin
      travel += hop(arm, order[i-1]);
      arm     = order[i-1];
      stops_due.push_back(mk_stop(arm, travel, 1'b0, i == 1));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stops_due.delete();
      batch_len    = 0;
      batch_lost   = 1'b0;
      start_cyl    = StartReset;
      top_cyl      = TopReset;
      fail_count_o = 0;
      stops_due_o  = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegStart) start_cyl = cfg_wdata_i;
        else if (cfg_idx_i == RegTop) top_cyl = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (batch_len < MaxBatch) begin
          batch_cyl[batch_len] = s_axis_tdata[CylW-1:0];
          batch_len++;
        end else begin
          batch_lost = 1'b1;
        end
        if (s_axis_tlast) begin
          plan_scan();
          batch_len  = 0;
          batch_lost = 1'b0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (stops_due.size() == 0) begin
          report("stop item with none due, stop_cylinder", m_axis_tdata[CylW-1:0], -1);
        end else begin
          want = stops_due.pop_front();
          if (m_axis_tdata[CylW-1:0] !== want.cyl)
            report("stop_cylinder", m_axis_tdata[CylW-1:0], want.cyl);
          if (m_axis_tdata[CylW+TotW-1:CylW] !== want.travel)
            report("movement_total", m_axis_tdata[CylW+TotW-1:CylW], want.travel);
          if (m_axis_tuser[0] !== want.turn)
            report("turn_point", m_axis_tuser[0], want.turn);
          if (m_axis_tuser[1] !== want.lost)
            report("dropped_requests", m_axis_tuser[1], want.lost);
          if (m_axis_tlast !== want.last)
            report("last_stop", m_axis_tlast, want.last);
          if (m_axis_tdata[OutDataW-1:CylW+TotW] !== '0)
            report("tdata pad", m_axis_tdata[OutDataW-1:CylW+TotW], 0);
        end
      end
      stops_due_o = stops_due.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top for scan_disk_arm_scheduler_unit: clock, reset, register writes,
// request batches with random gaps and output stalls, and the verdict.
// Depends on sdas_pkg, scan_disk_arm_scheduler_unit and sdas_stop_checker.
`timescale 1ns / 1ps
module tb;
  import sdas_pkg::*;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [RegIdxW-1:0]  cfg_idx   = RegStart;
  logic [CylW-1:0]     cfg_wdata = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic                s_tlast   = 1'b0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [OutUserW-1:0] m_tuser;
  logic                m_tlast;

  int              fail_count;
  int              stops_pending;
  int              items_sent = 0;
  bit              calm_phase = 1'b0;
  logic [CylW-1:0] cur_start  = StartReset;
  logic [CylW-1:0] cur_top    = TopReset;

  scan_disk_arm_scheduler_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  sdas_stop_checker u_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .fail_count_o  (fail_count),
    .stops_due_o   (stops_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int draw_gap();
    return calm_phase ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [CylW-1:0] pick_cyl();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return cur_start;
      3: return cur_top;
      4: return (cur_top == '1) ? cur_top : cur_top + 1'b1;
      default: return CylW'($urandom_range(0, (1 << CylW) - 1));
    endcase
  endfunction

  function automatic int pick_len();
    case ($urandom_range(0, 15))
      0: return $urandom_range(MaxBatch + 1, MaxBatch + 6);
      1, 2: return $urandom_range(16, MaxBatch);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  task automatic send_request(input logic [CylW-1:0] cyl, input logic lst);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= InDataW'(cyl);
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_batch(input int len);
    for (int i = 0; i < len; i++) send_request(pick_cyl(), i == len - 1);
  endtask

  // wait for every due stop, then let the block clear
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (stops_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [CylW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx == RegStart) cur_start = val;
    else cur_top = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // output side: random stall ahead of each item
  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    int s;
    int t;
    int phase_end;
    wait (rst_n);
    @(posedge clk);

    // reset settings: single request at zero, then saturation above top
    send_request(10'd0, 1'b1);
    settle();
    send_request(10'd1023, 1'b0);
    send_request(10'd500, 1'b0);
    send_request(10'd999, 1'b0);
    send_request(10'd5, 1'b1);
    settle();
    // arm already at top: turnaround with no travel
    write_reg(RegStart, 10'd1023);
    write_reg(RegTop, 10'd1023);
    send_request(10'd1023, 1'b0);
    send_request(10'd0, 1'b0);
    send_request(10'd512, 1'b1);
    settle();
    // start above top
    write_reg(RegStart, 10'd600);
    write_reg(RegTop, 10'd400);
    send_request(10'd100, 1'b0);
    send_request(10'd700, 1'b0);
    send_request(10'd400, 1'b0);
    send_request(10'd600, 1'b1);
    settle();
    write_reg(RegStart, 10'd300);
    write_reg(RegTop, 10'd1);
    send_request(10'd0, 1'b0);
    send_request(10'd1, 1'b0);
    send_request(10'd2, 1'b1);
    settle();
    // requests equal to and below the start
    write_reg(RegStart, 10'd500);
    write_reg(RegTop, 10'd999);
    send_request(10'd10, 1'b0);
    send_request(10'd499, 1'b0);
    send_request(10'd500, 1'b1);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin s = 0;    t = 1023; end
        1: begin s = 1023; t = 1;    end
        2: begin s = 0;    t = 1;    end
        3: begin s = 1023; t = 1023; end
        default: begin
          s = $urandom_range(0, 1023);
          t = $urandom_range(1, 1023);
        end
      endcase
      calm_phase = (phase == 2 || phase == 5);
      write_reg(RegStart, CylW'(s));
      write_reg(RegTop, CylW'(t));
      phase_end = items_sent + 42;
      while (items_sent < phase_end) send_batch(pick_len());
      settle();
    end

    calm_phase = 1'b0;
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
